>>> rtl/core/pidt_pkg.sv
// pidt_pkg: shared widths, register codes and reset values for the turn controller
// no dependencies; imported by pidt_error_stage and pid_turn_controller
`default_nettype none

package pidt_pkg;

  localparam int GAIN_WIDTH     = 20;
  localparam int LIMIT_WIDTH    = 8;
  localparam int BAND_WIDTH     = 16;
  localparam int VELOCITY_WIDTH = 9;

  // the integral product is capped at 2^TERM_SAT_BIT in magnitude before the sum
  localparam int TERM_SAT_BIT = 60;
  localparam int TERM_WIDTH   = 62;
  localparam int SUM_WIDTH    = 64;

  localparam int DEF_POSITION_WIDTH = 24;
  localparam int DEF_GAIN_FRAC_BITS = 16;
  localparam int DEF_INTEGRAL_WIDTH = 32;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_GOAL        = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_VEL_LIMIT   = 3'd4,
    REG_INT_BELOW   = 3'd5,
    REG_SETTLE_BAND = 3'd6
  } cfg_reg_t;

  localparam int                    RST_GOAL        = 0;
  localparam logic [GAIN_WIDTH-1:0] RST_GAIN_P      = 20'd51118;
  localparam logic [GAIN_WIDTH-1:0] RST_GAIN_I      = 20'd131;
  localparam logic [GAIN_WIDTH-1:0] RST_GAIN_D      = 20'd66;
  localparam logic [LIMIT_WIDTH-1:0] RST_VEL_LIMIT  = 8'd70;
  localparam int                    RST_INT_BELOW   = 100;
  localparam logic [BAND_WIDTH-1:0] RST_SETTLE_BAND = 16'd4;

endpackage

`default_nettype wire

>>> rtl/core/pidt_error_stage.sv
// pidt_error_stage: error, derivative and saturating conditional integral
// holds the integral and previous error state; uses pidt_pkg
`default_nettype none

module pidt_error_stage #(
  parameter int POSITION_WIDTH = pidt_pkg::DEF_POSITION_WIDTH,
  parameter int INTEGRAL_WIDTH = pidt_pkg::DEF_INTEGRAL_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [POSITION_WIDTH-1:0] goal_position,
  input  logic signed [POSITION_WIDTH-1:0] integrate_below,
  input  logic signed [POSITION_WIDTH-1:0] position,
  input  logic                             restart,
  input  logic                             advance,
  output logic signed [POSITION_WIDTH:0]   error,
  output logic signed [POSITION_WIDTH+1:0] derivative,
  output logic signed [INTEGRAL_WIDTH-1:0] integral
);

  import pidt_pkg::*;

  localparam int ERR_WIDTH = POSITION_WIDTH + 1;
  localparam int ACC_WIDTH = ((INTEGRAL_WIDTH > ERR_WIDTH) ? INTEGRAL_WIDTH : ERR_WIDTH) + 1;

  logic signed [INTEGRAL_WIDTH-1:0] error_sum;
  logic signed [ERR_WIDTH-1:0]      last_error;

  logic signed [INTEGRAL_WIDTH-1:0] sum_base;
  logic signed [ERR_WIDTH-1:0]      last_base;
  logic signed [ACC_WIDTH-1:0]      acc;
  logic signed [INTEGRAL_WIDTH-1:0] acc_sat;
  logic                             acc_fits;
  logic                             below;

  always_comb begin
    sum_base  = restart ? '0 : error_sum;
    last_base = restart ? ERR_WIDTH'(goal_position) : last_error;
    error     = ERR_WIDTH'(goal_position) - ERR_WIDTH'(position);
    below     = error < ERR_WIDTH'(integrate_below);
    acc       = ACC_WIDTH'(sum_base) + ACC_WIDTH'(error);
    acc_fits  = (&acc[ACC_WIDTH-1:INTEGRAL_WIDTH-1]) || !(|acc[ACC_WIDTH-1:INTEGRAL_WIDTH-1]);
    if (acc_fits) begin
      acc_sat = acc[INTEGRAL_WIDTH-1:0];
    end else if (acc[ACC_WIDTH-1]) begin
      acc_sat = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    end
    integral   = below ? acc_sat : sum_base;
    derivative = (POSITION_WIDTH+2)'(error) - (POSITION_WIDTH+2)'(last_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (advance) begin
      error_sum  <= integral;
      last_error <= error;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pid_turn_controller.sv
// pid_turn_controller: top level of the pid turn controller, five register stages
// uses pidt_pkg and pidt_error_stage
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_write            cfg_index, cfg_data
//   sample    in         in_valid / in_stall  measured_position, restart
//   command   out        out_valid/out_stall  left_velocity, right_velocity, settled
//
// one word per cycle sustained while out_stall is low; a word that is taken passes in turn
// through the input, error, product, term and output registers
// the integral and previous error update once per word, in the error stage
// synchronous reset clears state and valid flags and sets config registers to their reset values
// each stage holds only while the one after it is full and held, so empty stages keep
// taking words while a result waits
`default_nettype none

module pid_turn_controller #(
  parameter int POSITION_WIDTH = pidt_pkg::DEF_POSITION_WIDTH,
  parameter int GAIN_FRAC_BITS = pidt_pkg::DEF_GAIN_FRAC_BITS,
  parameter int INTEGRAL_WIDTH = pidt_pkg::DEF_INTEGRAL_WIDTH,
  localparam int CFG_DATA_WIDTH =
    (POSITION_WIDTH > pidt_pkg::GAIN_WIDTH) ? POSITION_WIDTH : pidt_pkg::GAIN_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_write,
  input  logic [pidt_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]                  cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic signed [POSITION_WIDTH-1:0]           measured_position,
  input  logic                                       restart,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [pidt_pkg::VELOCITY_WIDTH-1:0] left_velocity,
  output logic signed [pidt_pkg::VELOCITY_WIDTH-1:0] right_velocity,
  output logic                                       settled
);

  import pidt_pkg::*;

  localparam int ERR_WIDTH  = POSITION_WIDTH + 1;
  localparam int DER_WIDTH  = POSITION_WIDTH + 2;
  localparam int PE_WIDTH   = GAIN_WIDTH + ERR_WIDTH;
  localparam int PD_WIDTH   = GAIN_WIDTH + DER_WIDTH;
  localparam int I_LO_WIDTH = (INTEGRAL_WIDTH + 1) / 2;
  localparam int I_HI_WIDTH = INTEGRAL_WIDTH - I_LO_WIDTH;
  localparam int PIL_WIDTH  = GAIN_WIDTH + I_LO_WIDTH;
  localparam int PIH_WIDTH  = GAIN_WIDTH + I_HI_WIDTH;
  localparam int PI_WIDTH   = GAIN_WIDTH + INTEGRAL_WIDTH;
  localparam int CAP_WIDTH  = (PI_WIDTH > TERM_SAT_BIT + 1) ? PI_WIDTH : TERM_SAT_BIT + 1;
  localparam int BAND_CMP_WIDTH = (ERR_WIDTH > BAND_WIDTH) ? ERR_WIDTH : BAND_WIDTH;
  localparam logic [CAP_WIDTH-1:0] TERM_CAP = CAP_WIDTH'(1) << TERM_SAT_BIT;

  // configuration registers
  logic signed [POSITION_WIDTH-1:0] goal_position;
  logic [GAIN_WIDTH-1:0]            gain_p;
  logic [GAIN_WIDTH-1:0]            gain_i;
  logic [GAIN_WIDTH-1:0]            gain_d;
  logic [LIMIT_WIDTH-1:0]           velocity_limit;
  logic signed [POSITION_WIDTH-1:0] integrate_below;
  logic [BAND_WIDTH-1:0]            settle_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_position   <= POSITION_WIDTH'(RST_GOAL);
      gain_p          <= RST_GAIN_P;
      gain_i          <= RST_GAIN_I;
      gain_d          <= RST_GAIN_D;
      velocity_limit  <= RST_VEL_LIMIT;
      integrate_below <= POSITION_WIDTH'(RST_INT_BELOW);
      settle_band     <= RST_SETTLE_BAND;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GOAL:        goal_position   <= cfg_data[POSITION_WIDTH-1:0];
        REG_GAIN_P:      gain_p          <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_I:      gain_i          <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_D:      gain_d          <= cfg_data[GAIN_WIDTH-1:0];
        REG_VEL_LIMIT:   velocity_limit  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_INT_BELOW:   integrate_below <= cfg_data[POSITION_WIDTH-1:0];
        REG_SETTLE_BAND: settle_band     <= cfg_data[BAND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready = !out_valid || !out_stall;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) s3_valid  <= s2_valid;
      if (s4_ready) s4_valid  <= s3_valid;
      if (s5_ready) out_valid <= s4_valid;
    end
  end

  // stage 1: input register
  logic signed [POSITION_WIDTH-1:0] s1_position;
  logic                             s1_restart;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_position <= measured_position;
      s1_restart  <= restart;
    end
  end

  logic signed [ERR_WIDTH-1:0]      s1_error;
  logic signed [DER_WIDTH-1:0]      s1_derivative;
  logic signed [INTEGRAL_WIDTH-1:0] s1_integral;

  pidt_error_stage #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_error (
    .clk             (clk),
    .rst             (rst),
    .goal_position   (goal_position),
    .integrate_below (integrate_below),
    .position        (s1_position),
    .restart         (s1_restart),
    .advance         (s1_valid && s2_ready),
    .error           (s1_error),
    .derivative      (s1_derivative),
    .integral        (s1_integral)
  );

  // stage 2: error register, magnitudes and products
  logic signed [ERR_WIDTH-1:0]      s2_error;
  logic signed [DER_WIDTH-1:0]      s2_derivative;
  logic signed [INTEGRAL_WIDTH-1:0] s2_integral;
  logic                             s2_goal_neg;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_error      <= s1_error;
      s2_derivative <= s1_derivative;
      s2_integral   <= s1_integral;
      s2_goal_neg   <= goal_position[POSITION_WIDTH-1];
    end
  end

  logic [ERR_WIDTH-1:0]      err_mag;
  logic [DER_WIDTH-1:0]      der_mag;
  logic [INTEGRAL_WIDTH-1:0] int_mag;
  logic [PE_WIDTH-1:0]       prod_e;
  logic [PD_WIDTH-1:0]       prod_d;
  logic [PIL_WIDTH-1:0]      prod_il;
  logic [PIH_WIDTH-1:0]      prod_ih;
  logic                      near_goal;

  always_comb begin
    err_mag   = s2_error[ERR_WIDTH-1] ? ERR_WIDTH'(-s2_error) : ERR_WIDTH'(s2_error);
    der_mag   = s2_derivative[DER_WIDTH-1] ? DER_WIDTH'(-s2_derivative)
                                           : DER_WIDTH'(s2_derivative);
    int_mag   = s2_integral[INTEGRAL_WIDTH-1] ? INTEGRAL_WIDTH'(-s2_integral)
                                              : INTEGRAL_WIDTH'(s2_integral);
    prod_e    = PE_WIDTH'(gain_p) * PE_WIDTH'(err_mag);
    prod_d    = PD_WIDTH'(gain_d) * PD_WIDTH'(der_mag);
    prod_il   = PIL_WIDTH'(gain_i) * PIL_WIDTH'(int_mag[I_LO_WIDTH-1:0]);
    prod_ih   = PIH_WIDTH'(gain_i) * PIH_WIDTH'(int_mag[INTEGRAL_WIDTH-1:I_LO_WIDTH]);
    near_goal = BAND_CMP_WIDTH'(err_mag) < BAND_CMP_WIDTH'(settle_band);
  end

  // stage 3: product register, integral product rebuilt and capped
  logic [PE_WIDTH-1:0]  s3_prod_e;
  logic [PD_WIDTH-1:0]  s3_prod_d;
  logic [PIL_WIDTH-1:0] s3_prod_il;
  logic [PIH_WIDTH-1:0] s3_prod_ih;
  logic                 s3_neg_e, s3_neg_d, s3_neg_i;
  logic                 s3_settled;
  logic                 s3_goal_neg;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_prod_e   <= prod_e;
      s3_prod_d   <= prod_d;
      s3_prod_il  <= prod_il;
      s3_prod_ih  <= prod_ih;
      s3_neg_e    <= s2_error[ERR_WIDTH-1];
      s3_neg_d    <= s2_derivative[DER_WIDTH-1];
      s3_neg_i    <= s2_integral[INTEGRAL_WIDTH-1];
      s3_settled  <= near_goal;
      s3_goal_neg <= s2_goal_neg;
    end
  end

  logic [CAP_WIDTH-1:0]         prod_i;
  logic [CAP_WIDTH-1:0]         prod_i_cap;
  logic signed [TERM_WIDTH-1:0] mag_e, mag_d, mag_i;
  logic signed [TERM_WIDTH-1:0] term_e, term_d, term_i;

  // proportional and derivative products stay well under the cap
  always_comb begin
    prod_i     = (CAP_WIDTH'(s3_prod_ih) << I_LO_WIDTH) + CAP_WIDTH'(s3_prod_il);
    prod_i_cap = (prod_i > TERM_CAP) ? TERM_CAP : prod_i;
    mag_e      = TERM_WIDTH'(s3_prod_e);
    mag_d      = TERM_WIDTH'(s3_prod_d);
    mag_i      = TERM_WIDTH'(prod_i_cap);
    term_e     = s3_neg_e ? -mag_e : mag_e;
    term_d     = s3_neg_d ? -mag_d : mag_d;
    term_i     = s3_neg_i ? -mag_i : mag_i;
  end

  // stage 4: term register, sum, scale and clamp
  logic signed [TERM_WIDTH-1:0] s4_term_e, s4_term_d, s4_term_i;
  logic                         s4_settled;
  logic                         s4_goal_neg;

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_term_e   <= term_e;
      s4_term_d   <= term_d;
      s4_term_i   <= term_i;
      s4_settled  <= s3_settled;
      s4_goal_neg <= s3_goal_neg;
    end
  end

  logic signed [SUM_WIDTH-1:0]      total;
  logic [SUM_WIDTH-1:0]             total_mag;
  logic [SUM_WIDTH-1:0]             scaled;
  logic signed [VELOCITY_WIDTH-1:0] limit_s;
  logic signed [VELOCITY_WIDTH-1:0] scaled_s;
  logic signed [VELOCITY_WIDTH-1:0] command;

  always_comb begin
    total     = SUM_WIDTH'(s4_term_e) + SUM_WIDTH'(s4_term_i) + SUM_WIDTH'(s4_term_d);
    total_mag = total[SUM_WIDTH-1] ? SUM_WIDTH'(-total) : SUM_WIDTH'(total);
    scaled    = total_mag >> GAIN_FRAC_BITS;
    limit_s   = VELOCITY_WIDTH'(velocity_limit);
    scaled_s  = VELOCITY_WIDTH'(scaled[LIMIT_WIDTH-1:0]);
    if (scaled > SUM_WIDTH'(velocity_limit)) begin
      command = s4_goal_neg ? -limit_s : limit_s;
    end else begin
      command = total[SUM_WIDTH-1] ? -scaled_s : scaled_s;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (s5_ready) begin
      left_velocity  <= command;
      right_velocity <= -command;
      settled        <= s4_settled;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && s3_valid && s4_valid && out_valid && out_stall))
    else $error("input held while the pipeline has room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !(out_valid && out_stall) |=> out_valid)
    else $error("finished word did not reach the output register");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_position) && $stable(s1_restart))
    else $error("held input word changed");

endmodule

`default_nettype wire
